>>> hw/rtl/absq_pkg.sv
// ----------------------------------------------------------------------------
// absq_pkg: shared types and constants of the per-row absmax int8 quantizer
// Transaction structs for both channels, float constants and the
// single-to-half scale conversion.
// ----------------------------------------------------------------------------
package absq_pkg;

  localparam logic OP_MEASURE  = 1'b0;
  localparam logic OP_QUANTIZE = 1'b1;

  localparam logic KIND_SCALE  = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F32_127     = 32'h42FE_0000;
  localparam logic [30:0] F32_INF_MAG = 31'h7F80_0000;
  localparam logic [15:0] F16_INF     = 16'h7C00;

  typedef struct packed {
    logic        opcode;
    logic [31:0] value_bits;
    logic        row_end;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [15:0]       scale_half;
    logic signed [7:0] weight;
  } out_item_t;

  // Round a 24-bit value right by sh places, nearest even.
  function automatic logic [23:0] round_shift(input logic [23:0] m, input logic [4:0] sh);
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] half;
    q    = m >> sh;
    rem  = m & ((24'd1 << sh) - 24'd1);
    half = 24'd1 << (sh - 5'd1);
    if ((rem > half) || ((rem == half) && q[0])) begin
      q = q + 24'd1;
    end
    return q;
  endfunction

  // Positive single-precision value (never NaN) to half-precision bits.
  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic [7:0]        ex;
    logic [22:0]       man;
    logic signed [9:0] e;
    logic [23:0]       rq;
    logic [15:0]       res;
    ex  = b[30:23];
    man = b[22:0];
    e   = $signed({2'b00, ex}) - 10'sd112;
    rq  = 24'd0;
    if (ex == 8'd0) begin
      res = 16'd0;
    end else if (ex == 8'hFF) begin
      res = F16_INF;
    end else if (e >= 10'sd31) begin
      res = F16_INF;
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        res = 16'd0;
      end else begin
        rq  = round_shift({1'b1, man}, 5'(10'sd14 - e));
        res = rq[15:0];
      end
    end else begin
      rq  = round_shift({1'b0, man}, 5'd13);
      res = {1'b0, e[4:0], 10'd0} + rq[15:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/per_row_absmax_int8_quantizer_core.sv
// ----------------------------------------------------------------------------
// per_row_absmax_int8_quantizer_core: per-row symmetric int8 quantizer
// Measures the largest magnitude of a row, emits the half-precision scale
// amax/127 and quantizes the second pass of the row with its reciprocal.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | into core | in_valid / in_stall  | in_data  (opcode, value, end)
//  out     | from core | out_valid / out_stall| out_data (kind, scale, weight)
//
//  Steps: a measure element that does not end the row updates the maximum;
//  a zero or infinite row maximum goes straight to output. Any other row end
//  runs amax/127 by estimate and up to 4 corrections, then 26 divider steps
//  for 1/d. A quantize element runs multiply, normalise, round and output,
//  or output alone when NaN, infinity or zero decides it; subnormals add shifts.
//  Reset (rst, synchronous) clears the maximum, the reciprocal and control.
//  in_stall is high while an item is in flight; a full output register
//  under out_stall holds the finished transaction until it is taken.
// ----------------------------------------------------------------------------
module per_row_absmax_int8_quantizer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  absq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output absq_pkg::out_item_t out_data
);
  import absq_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NORM   = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_ALIGN  = 4'd3;
  localparam logic [3:0] S_DENORM = 4'd4;
  localparam logic [3:0] S_PACK   = 4'd5;
  localparam logic [3:0] S_HALF   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_QNORM  = 4'd8;
  localparam logic [3:0] S_QFIN   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_CFIX   = 4'd11;

  localparam logic [4:0]  DIV_LAST = 5'd25;
  localparam logic [24:0] REM_127  = 25'd127;

  logic [3:0]         state;
  logic               phase;        // 0: amax/127, 1: 1/d
  logic [30:0]        running_max;
  logic [31:0]        reciprocal;
  logic [31:0]        xbits;
  logic [31:0]        dval;

  // shared divider / normaliser registers
  logic [23:0]        ma;
  logic [23:0]        mb;
  logic signed [9:0]  ea;
  logic signed [9:0]  eb;
  logic [24:0]        rem;
  logic [25:0]        quo;
  logic [4:0]         cnt;
  logic [23:0]        sig;
  logic               grd;
  logic               stk;
  logic signed [10:0] ex;
  logic [47:0]        prod;

  // pending result
  logic               res_kind;
  logic [15:0]        res_scale;
  logic [7:0]         res_weight;

  logic               in_acc;
  logic               out_free;
  logic [30:0]        mag;
  logic [30:0]        max_next;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign mag      = in_data.value_bits[30:0];
  assign max_next = ((mag <= F32_INF_MAG) && (mag > running_max)) ? mag : running_max;

  // unpack a float: significand with hidden bit, effective exponent
  function automatic logic [23:0] unpack_man(input logic [31:0] b);
    return {(b[30:23] != 8'd0), b[22:0]};
  endfunction

  function automatic logic [7:0] unpack_exp(input logic [31:0] b);
    return (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  endfunction

  // divider step
  logic        div_ge;
  logic [24:0] div_rn;
  assign div_ge = (rem >= {1'b0, mb});
  assign div_rn = div_ge ? (rem - {1'b0, mb}) : rem;

  // amax / 127: estimate the quotient from 127 = 2^7 - 1 (never too high),
  // then correct it by compare and subtract
  logic [31:0] c_num;
  logic [25:0] c_quo;
  logic [33:0] c_rem;
  assign c_num = {ma, 8'd0};
  assign c_quo = 26'(c_num >> 7) + 26'(c_num >> 14) + 26'(c_num >> 21)
               + 26'(c_num >> 28);
  assign c_rem = {2'b00, c_num} - {1'b0, c_quo, 7'd0} + {8'd0, c_quo};

  // rounding and packing of the divider result
  logic        pk_inc;
  logic [24:0] pk_sig;
  logic [31:0] pk_sum;
  logic [31:0] pk_bits;
  always_comb begin
    pk_inc = grd && (stk || sig[0]);
    pk_sig = {1'b0, sig} + {24'd0, pk_inc};
    pk_sum = {1'b0, 8'(ex - 11'sd1), 23'd0} + {7'd0, pk_sig};
    if (ex >= 11'sd255) begin
      pk_bits = {1'b0, F32_INF_MAG};
    end else if (pk_sum >= {1'b0, F32_INF_MAG}) begin
      pk_bits = {1'b0, F32_INF_MAG};
    end else begin
      pk_bits = pk_sum;
    end
  end

  // final rounding of a quantize product: float rounding, then to integer
  logic signed [10:0] q_e;
  logic               q_inc;
  logic [24:0]        q_m;
  logic [4:0]         q_k;
  logic [24:0]        q_int;
  logic [24:0]        q_half;
  logic [8:0]         q_n;
  logic [7:0]         q_mag;
  always_comb begin
    q_e    = ex - 11'sd253;
    q_inc  = prod[23] && ((prod[22:0] != 23'd0) || prod[24]);
    q_m    = {1'b0, prod[47:24]} + {24'd0, q_inc};
    q_k    = 5'(11'sd23 - q_e);
    q_int  = q_m >> q_k;
    q_half = q_m >> (q_k - 5'd1);
    q_n    = q_int[8:0] + {8'd0, q_half[0]};
    if (q_e < -11'sd2) begin
      q_mag = 8'd0;
    end else if (q_e >= 11'sd7) begin
      q_mag = 8'd127;
    end else if (q_n > 9'd127) begin
      q_mag = 8'd127;
    end else begin
      q_mag = q_n[7:0];
    end
  end

  // quantize operand classes
  logic x_nan, x_inf, x_zero, r_inf, r_zero;
  assign x_nan  = (xbits[30:23] == 8'hFF) && (xbits[22:0] != 23'd0);
  assign x_inf  = (xbits[30:0] == F32_INF_MAG);
  assign x_zero = (xbits[30:0] == 31'd0);
  assign r_inf  = (reciprocal[30:0] == F32_INF_MAG);
  assign r_zero = (reciprocal[30:0] == 31'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= 1'b0;
      running_max <= 31'd0;
      reciprocal  <= 32'd0;
      out_valid   <= 1'b0;
    end else begin
      // raise the output when a transaction is ready, drop it once taken
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.opcode == OP_MEASURE) begin
              running_max <= max_next;
              if (in_data.row_end) begin
                res_kind   <= KIND_SCALE;
                res_weight <= 8'd0;
                if (max_next == 31'd0) begin
                  res_scale  <= 16'd0;
                  reciprocal <= 32'd0;
                  state      <= S_OUT;
                end else if (max_next == F32_INF_MAG) begin
                  res_scale  <= F16_INF;
                  reciprocal <= 32'd0;
                  state      <= S_OUT;
                end else begin
                  // start amax / 127
                  ma    <= unpack_man({1'b0, max_next});
                  ea    <= $signed({2'b00, unpack_exp({1'b0, max_next})});
                  mb    <= unpack_man(F32_127);
                  eb    <= $signed({2'b00, unpack_exp(F32_127)});
                  phase <= 1'b0;
                  state <= S_NORM;
                end
              end
            end else begin
              xbits <= in_data.value_bits;
              if (in_data.row_end) begin
                running_max <= 31'd0;
              end
              state <= S_MUL;
            end
          end
        end
        S_NORM: begin
          // normalise subnormal operands one place a cycle
          if (ma[23] && mb[23]) begin
            if (phase == 1'b0) begin
              quo   <= c_quo;
              rem   <= c_rem[24:0];
              state <= S_CFIX;
            end else begin
              rem   <= {1'b0, ma};
              quo   <= 26'd0;
              cnt   <= 5'd0;
              state <= S_DIV;
            end
          end else begin
            if (!ma[23]) begin
              ma <= {ma[22:0], 1'b0};
              ea <= ea - 10'sd1;
            end
            if (!mb[23]) begin
              mb <= {mb[22:0], 1'b0};
              eb <= eb - 10'sd1;
            end
          end
        end
        S_CFIX: begin
          // advance the estimate until the remainder is below 127
          if (rem >= REM_127) begin
            quo <= quo + 26'd1;
            rem <= rem - REM_127;
          end else begin
            state <= S_ALIGN;
          end
        end
        S_DIV: begin
          quo <= {quo[24:0], div_ge};
          rem <= {div_rn[23:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) begin
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (quo[25]) begin
            sig <= quo[25:2];
            grd <= quo[1];
            stk <= quo[0] || (rem != 25'd0);
            ex  <= $signed({ea[9], ea}) - $signed({eb[9], eb}) + 11'sd127;
          end else begin
            sig <= quo[24:1];
            grd <= quo[0];
            stk <= (rem != 25'd0);
            ex  <= $signed({ea[9], ea}) - $signed({eb[9], eb}) + 11'sd126;
          end
          state <= S_DENORM;
        end
        S_DENORM: begin
          // shift a subnormal result right, folding lost bits into sticky
          if (ex < 11'sd1) begin
            if (ex < -11'sd25) begin
              sig <= 24'd0;
              grd <= 1'b0;
              stk <= 1'b1;
              ex  <= 11'sd1;
            end else begin
              stk <= stk || grd;
              grd <= sig[0];
              sig <= {1'b0, sig[23:1]};
              ex  <= ex + 11'sd1;
            end
          end else begin
            state <= S_PACK;
          end
        end
        S_PACK: begin
          if (phase == 1'b0) begin
            dval  <= pk_bits;
            state <= S_HALF;
          end else begin
            reciprocal <= pk_bits;
            state      <= S_OUT;
          end
        end
        S_HALF: begin
          res_scale <= to_half(dval);
          if (dval == 32'd0) begin
            reciprocal <= 32'd0;
            state      <= S_OUT;
          end else begin
            // start 1 / d
            ma    <= unpack_man(F32_ONE);
            ea    <= $signed({2'b00, unpack_exp(F32_ONE)});
            mb    <= unpack_man(dval);
            eb    <= $signed({2'b00, unpack_exp(dval)});
            phase <= 1'b1;
            state <= S_NORM;
          end
        end
        S_MUL: begin
          res_kind  <= KIND_WEIGHT;
          res_scale <= 16'd0;
          if (x_nan) begin
            res_weight <= 8'd0;
            state      <= S_OUT;
          end else if (x_inf) begin
            res_weight <= r_zero ? 8'd0 : (xbits[31] ? -8'sd127 : 8'sd127);
            state      <= S_OUT;
          end else if (r_inf) begin
            res_weight <= x_zero ? 8'd0 : (xbits[31] ? -8'sd127 : 8'sd127);
            state      <= S_OUT;
          end else if (x_zero || r_zero) begin
            res_weight <= 8'd0;
            state      <= S_OUT;
          end else begin
            prod  <= unpack_man(xbits) * unpack_man(reciprocal);
            ex    <= $signed({3'b000, unpack_exp(xbits)})
                   + $signed({3'b000, unpack_exp(reciprocal)});
            state <= S_QNORM;
          end
        end
        S_QNORM: begin
          if (prod[47]) begin
            state <= S_QFIN;
          end else begin
            prod <= {prod[46:0], 1'b0};
            ex   <= ex - 11'sd1;
          end
        end
        S_QFIN: begin
          res_weight <= xbits[31] ? (8'd0 - q_mag) : q_mag;
          state      <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            out_data.kind       <= res_kind;
            out_data.scale_half <= res_scale;
            out_data.weight     <= $signed(res_weight);
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.weight != -8'sd128))
    else $error("weight outside -127..127");

  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.kind == KIND_WEIGHT) ? (out_data.scale_half == 16'd0)
                                                  : (out_data.weight == 8'sd0)))
    else $error("unused result field not zero");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && (cnt != DIV_LAST) |=> (state == S_DIV))
    else $error("divider left early");

  a_qfin_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_QFIN) |-> prod[47])
    else $error("product not normalised");
`endif

endmodule

>>> bench/tb_per_row_absmax_int8_quantizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_row_absmax_int8_quantizer_core: self-checking bench for the quantizer
// Streams rows twice (measure, then quantize) with random gaps on both sides,
// predicts every scale and weight transaction in its own float arithmetic
// and compares each output transaction field by field, in order.
// ----------------------------------------------------------------------------

// Tracks row maximum and reciprocal, and queues the expected transactions.
class quant_scoreboard;
  logic [31:0]         row_max;
  logic [31:0]         recip;
  absq_pkg::out_item_t expected_q[$];
  int                  errors;

  function new();
    row_max = '0;
    recip   = '0;
    errors  = 0;
  endfunction

  // Append one expected transaction at the tail of the queue.
  function void expect_result(input absq_pkg::out_item_t res);
    expected_q.insert(expected_q.size(), res);
  endfunction

  // Shift right with round to nearest, ties to even.
  function logic [63:0] rne(input logic [63:0] m, input int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    if (sh > 63) return '0;
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Double to single precision bits; the double result of a single operation
  // rounds to the same value as the single operation would.
  function logic [31:0] to_single(input real r);
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] q;
    int          e;
    b = $realtobits(r);
    if (b[62:52] == 11'h7FF) return {b[63], 31'h7F80_0000};
    if (b[62:52] == 11'd0) return {b[63], 31'd0};
    e = int'(b[62:52]) - 1023 + 127;
    m = {11'd0, 1'b1, b[51:0]};
    if (e >= 255) return {b[63], 31'h7F80_0000};
    if (e >= 1) begin
      q = rne(m, 29);
      return {b[63], 31'((64'(e) << 23) + q - (64'd1 << 23))};
    end
    if (30 - e > 60) return {b[63], 31'd0};
    q = rne(m, 30 - e);
    return {b[63], q[30:0]};
  endfunction

  function real to_real(input logic [31:0] f);
    real r;
    if (f[30:23] == 8'd0) begin
      r = real'(f[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      return f[31] ? -r : r;
    end
    if (f[30:23] == 8'hFF) return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
    return $bitstoreal({f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'd0});
  endfunction

  // Positive, non-NaN single to half precision bits.
  function logic [15:0] half_of(input logic [31:0] b);
    int          e;
    logic [63:0] q;
    e = int'(b[30:23]) - 112;
    if (b[30:23] == 8'd0) return 16'd0;
    if (b[30:23] == 8'hFF || e >= 31) return 16'h7C00;
    if (e <= 0) begin
      if (e < -10) return 16'd0;
      q = rne({40'd0, 1'b1, b[22:0]}, 14 - e);
      return q[15:0];
    end
    q = (64'(e) << 10) + rne({41'd0, b[22:0]}, 13);
    return q[15:0];
  endfunction

  function logic signed [7:0] weight_of(input logic [31:0] x);
    real         p;
    real         a;
    logic [31:0] pb;
    int          n;
    bit          xinf;
    bit          rinf;
    xinf = (x[30:0] == 31'h7F80_0000);
    rinf = (recip[30:0] == 31'h7F80_0000);
    if (x[30:23] == 8'hFF && !xinf) return 8'sd0;
    // zero times infinity is NaN
    if ((xinf && recip[30:0] == 0) || (rinf && x[30:0] == 0)) return 8'sd0;
    if (xinf || rinf) return (x[31] ^ recip[31]) ? -8'sd127 : 8'sd127;
    pb = to_single(to_real(x) * to_real(recip));
    p  = to_real(pb);
    if (p >= 127.0) return 8'sd127;
    if (p <= -127.0) return -8'sd127;
    a = (p < 0.0) ? -p : p;
    n = $rtoi(a);
    if (a - n >= 0.5) n++;
    return (p < 0.0) ? 8'(-n) : 8'(n);
  endfunction

  function void note_input(input absq_pkg::in_item_t it);
    logic [31:0]         mag;
    logic [31:0]         d;
    absq_pkg::out_item_t res;
    if (it.opcode == absq_pkg::OP_MEASURE) begin
      mag = {1'b0, it.value_bits[30:0]};
      if (mag <= 32'h7F80_0000 && mag > row_max) row_max = mag;
      if (it.row_end) begin
        d     = to_single(to_real(row_max) / 127.0);
        recip = (d[30:0] != 0) ? to_single(1.0 / to_real(d)) : 32'd0;
        res.kind       = absq_pkg::KIND_SCALE;
        res.scale_half = half_of(d);
        res.weight     = '0;
        expect_result(res);
      end
    end else begin
      res.kind       = absq_pkg::KIND_WEIGHT;
      res.scale_half = '0;
      res.weight     = weight_of(it.value_bits);
      expect_result(res);
      if (it.row_end) row_max = '0;
    end
  endfunction

  function void check(input absq_pkg::out_item_t got);
    absq_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected output transaction %h", got);
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind || got.scale_half !== want.scale_half ||
        got.weight !== want.weight) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: kind %b/%b scale %h/%h weight %0d/%0d (exp/got)",
                 want.kind, got.kind, want.scale_half, got.scale_half,
                 want.weight, got.weight);
    end
  endfunction
endclass

module tb_per_row_absmax_int8_quantizer_core;
  import absq_pkg::*;

  localparam int NUM_ITEMS   = 2000;
  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_LEN    = 400;
  localparam int MAX_ROW     = 32;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  quant_scoreboard sb = new();

  int tx_idle;        // sender gap probability, percent
  int rx_idle;        // receiver stall probability, percent
  int hold_reqs;      // long receiver hold-offs requested by the sender side
  int hold_served;
  int hold_left;
  int sent;
  int idle_cnt;

  per_row_absmax_int8_quantizer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offer one transaction, with a random gap ahead of it, and hold it until
  // taken. The scoreboard notes it at the accepting edge.
  task automatic send_item(input logic op, input logic [31:0] v, input logic last);
    in_item_t it;
    it.opcode     = op;
    it.value_bits = v;
    it.row_end    = last;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    sent++;
  endtask

  // Hold the sender until every expected transaction has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Random element near a row exponent, with special values mixed in.
  function automatic logic [31:0] rand_value(input int row_exp);
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 19))
      0:       v[30:0] = '0;
      1:       v[30:0] = 31'h7F80_0000;
      2:       v[30:23] = 8'hFF;                      // NaN unless mantissa is 0
      3:       v[30:23] = 8'h00;                      // subnormal
      4:       ;                                     // any pattern
      default: v[30:23] = 8'(row_exp - $urandom_range(0, 9));
    endcase
    return v;
  endfunction

  // Well-formed row: measure pass then the same elements quantized.
  task automatic send_row(input int len, input int row_exp);
    logic [31:0] vals [0:MAX_ROW-1];
    for (int i = 0; i < len; i++) vals[i] = rand_value(row_exp);
    for (int i = 0; i < len; i++) send_item(OP_MEASURE, vals[i], i == len - 1);
    for (int i = 0; i < len; i++) send_item(OP_QUANTIZE, vals[i], i == len - 1);
  endtask

  task automatic send_random_phase(input int upto);
    while (sent < upto) begin
      if ($urandom_range(0, 99) < 85) begin
        // mostly short rows, now and then a long one
        send_row(($urandom_range(0, 19) == 0) ? $urandom_range(10, MAX_ROW)
                                               : $urandom_range(1, 6),
                 $urandom_range(1, 254));
      end else begin
        send_item(1'($urandom()), rand_value($urandom_range(1, 254)), 1'($urandom()));
      end
    end
  endtask

  // Receiver: check taken transactions, then choose the next stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check(out_data);
      if (hold_served != hold_reqs) begin
        hold_served <= hold_served + 1;
        hold_left   <= HOLD_LEN;
        out_stall   <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCH_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    tx_idle   = 37;
    rx_idle   = 66;
    hold_reqs = 0;
    sent      = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Quantize before any measure end: reciprocal is still zero.
    send_item(OP_QUANTIZE, 32'h4000_0000, 1'b0);
    // All-zero row: scale 0, reciprocal 0.
    send_item(OP_MEASURE, 32'h8000_0000, 1'b1);
    send_item(OP_QUANTIZE, 32'h3F80_0000, 1'b1);
    // Max 127 gives reciprocal 1: halves round away from zero, clamp, NaN.
    send_item(OP_MEASURE, 32'h7FC0_0000, 1'b0);       // NaN ignored
    send_item(OP_MEASURE, 32'hC2FE_0000, 1'b1);       // -127
    send_item(OP_QUANTIZE, 32'h4020_0000, 1'b0);      // 2.5
    send_item(OP_QUANTIZE, 32'hC020_0000, 1'b0);      // -2.5
    send_item(OP_QUANTIZE, 32'h3F00_0000, 1'b0);      // 0.5
    send_item(OP_QUANTIZE, 32'h4348_0000, 1'b0);      // 200
    send_item(OP_QUANTIZE, 32'hFF80_0000, 1'b0);      // -inf
    send_item(OP_QUANTIZE, 32'h7FFF_FFFF, 1'b1);      // NaN
    // Infinite maximum: scale infinity, reciprocal 0, inf * 0 is NaN.
    send_item(OP_MEASURE, 32'hFF80_0000, 1'b1);
    send_item(OP_QUANTIZE, 32'h7F80_0000, 1'b0);
    send_item(OP_QUANTIZE, 32'h4000_0000, 1'b1);
    // Half overflow of the scale, then extreme patterns.
    send_item(OP_MEASURE, 32'h7F7F_FFFF, 1'b1);
    send_item(OP_QUANTIZE, 32'hFF7F_FFFF, 1'b1);
    // Subnormal maximum: scale underflows to zero.
    send_item(OP_MEASURE, 32'h0000_0001, 1'b1);
    send_item(OP_QUANTIZE, 32'h0000_0001, 1'b1);
    // Small maximum whose reciprocal overflows to infinity.
    send_item(OP_MEASURE, 32'h0080_0000, 1'b1);
    send_item(OP_QUANTIZE, 32'h0000_0000, 1'b0);
    send_item(OP_QUANTIZE, 32'h8000_0001, 1'b1);
    // Mixed opcodes within one row.
    send_item(OP_MEASURE, 32'h4100_0000, 1'b0);
    send_item(OP_QUANTIZE, 32'h3F80_0000, 1'b0);
    send_item(OP_MEASURE, 32'hFFFF_FFFF, 1'b1);

    send_random_phase(NUM_ITEMS / 3);
    drain();

    tx_idle = 66;
    rx_idle = 37;
    send_random_phase(2 * NUM_ITEMS / 3);

    // Long receiver hold-off while the sender keeps offering: fill the block.
    tx_idle   = 0;
    rx_idle   = 0;
    hold_reqs = hold_reqs + 1;
    send_random_phase(NUM_ITEMS);
    drain();

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> per_row_absmax_int8_quantizer_core.f
hw/rtl/absq_pkg.sv
hw/rtl/per_row_absmax_int8_quantizer_core.sv
bench/tb_per_row_absmax_int8_quantizer_core.sv
